@@ src/rrpm_pkg.sv @@
package rrpm_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int PATH_MAX    = 256;

  localparam int PAT_AW  = $clog2(PATTERN_MAX);
  localparam int PAT_LW  = $clog2(PATTERN_MAX + 1);
  localparam int PATH_AW = $clog2(PATH_MAX);
  localparam int PATH_LW = $clog2(PATH_MAX + 1);
  localparam int CMP_W   = (PAT_LW > PATH_LW) ? PAT_LW : PATH_LW;

  localparam logic [7:0] STAR   = 8'h2A;
  localparam logic [7:0] DOLLAR = 8'h24;

  localparam logic [1:0] OP_CLEAR_PAT  = 2'd0;
  localparam logic [1:0] OP_APPEND_PAT = 2'd1;
  localparam logic [1:0] OP_APPEND_PATH = 2'd2;
  localparam logic [1:0] OP_EVALUATE   = 2'd3;

  localparam int CFG_AW = 3;
  localparam logic REG_RULE_ALLOWS = 1'b0;

  typedef enum logic [3:0] {
    EV_IDLE,
    EV_SCAN_RD,
    EV_SCAN_DAT,
    EV_DECIDE,
    EV_CMP_RD,
    EV_CMP_DAT,
    EV_WALK_TOP,
    EV_WALK_DAT,
    EV_SKIP_DAT,
    EV_STAR_RD,
    EV_STAR_DAT,
    EV_DONE
  } ev_state_t;

  typedef struct packed {
    logic               start;
    logic [PAT_LW-1:0]  pat_len;
    logic [PATH_LW-1:0] path_len;
  } eval_req_t;

  typedef struct packed {
    logic done;
    logic matched;
  } eval_sts_t;

endpackage

@@ src/robots_rule_path_matcher_top.sv @@
// Channel   Ports                                        Handshake
// input     in_op, in_data_byte                          start & !busy
// result    out_matched, out_allow_rule, out_overflowed  out_valid, one cycle
// config    psel penable pwrite paddr pwdata prdata      APB, pready always 1
//
// Ops 0..2 act on the beat that is taken. Evaluate walks the pattern RAM once
// from the top, then compares or runs the wildcard walk, reading pattern and
// path bytes one at a time through the single read port of each RAM. busy
// rises after the evaluate beat is taken and stays high through the out_valid
// cycle. Reset clears lengths, flags and rule_allows; RAM contents are
// undefined. Results cannot be stalled.
module robots_rule_path_matcher_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_op,
  input  logic [7:0]                  in_data_byte,
  output logic                        out_valid,
  output logic                        out_matched,
  output logic                        out_allow_rule,
  output logic                        out_overflowed,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rrpm_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int PAT_LW  = rrpm_pkg::PAT_LW;
  localparam int PATH_LW = rrpm_pkg::PATH_LW;

  logic               rule_allows_r, rule_allows_nxt;
  logic [PAT_LW-1:0]  pat_len_r, pat_len_nxt;
  logic [PATH_LW-1:0] path_len_r, path_len_nxt;
  logic               pat_ovf_r, pat_ovf_nxt;
  logic               path_ovf_r, path_ovf_nxt;
  logic               busy_r, busy_nxt;
  logic               allow_cap_r, allow_cap_nxt;
  logic               ovf_cap_r, ovf_cap_nxt;

  logic accept;
  logic cfg_wr;
  logic pat_room;
  logic path_room;
  logic pat_we;
  logic path_we;

  logic [rrpm_pkg::PAT_AW-1:0]  pat_raddr;
  logic [rrpm_pkg::PATH_AW-1:0] path_raddr;
  logic [7:0]                   pat_rdata;
  logic [7:0]                   path_rdata;

  rrpm_pkg::eval_req_t ev_req;
  rrpm_pkg::eval_sts_t ev_sts;

  assign accept    = start && !busy_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pat_room  = (pat_len_r < PAT_LW'(rrpm_pkg::PATTERN_MAX));
  assign path_room = (path_len_r < PATH_LW'(rrpm_pkg::PATH_MAX));
  assign pat_we    = accept && (in_op == rrpm_pkg::OP_APPEND_PAT) && pat_room;
  assign path_we   = accept && (in_op == rrpm_pkg::OP_APPEND_PATH) && path_room;

  assign ev_req.start    = accept && (in_op == rrpm_pkg::OP_EVALUATE);
  assign ev_req.pat_len  = pat_len_r;
  assign ev_req.path_len = path_len_r;

  assign prdata = (paddr[2] == rrpm_pkg::REG_RULE_ALLOWS) ? {31'b0, rule_allows_r} : 32'b0;

  always_comb begin
    rule_allows_nxt = rule_allows_r;
    pat_len_nxt     = pat_len_r;
    path_len_nxt    = path_len_r;
    pat_ovf_nxt     = pat_ovf_r;
    path_ovf_nxt    = path_ovf_r;
    busy_nxt        = busy_r;
    allow_cap_nxt   = allow_cap_r;
    ovf_cap_nxt     = ovf_cap_r;
    if (cfg_wr && (paddr[2] == rrpm_pkg::REG_RULE_ALLOWS)) begin
      rule_allows_nxt = pwdata[0];
    end
    if (ev_sts.done) begin
      busy_nxt = 1'b0;
    end
    if (accept) begin
      case (in_op)
        rrpm_pkg::OP_CLEAR_PAT: begin
          pat_len_nxt = '0;
          pat_ovf_nxt = 1'b0;
        end
        rrpm_pkg::OP_APPEND_PAT: begin
          if (pat_room) begin
            pat_len_nxt = PAT_LW'(pat_len_r + 1'b1);
          end else begin
            pat_ovf_nxt = 1'b1;
          end
        end
        rrpm_pkg::OP_APPEND_PATH: begin
          if (path_room) begin
            path_len_nxt = PATH_LW'(path_len_r + 1'b1);
          end else begin
            path_ovf_nxt = 1'b1;
          end
        end
        rrpm_pkg::OP_EVALUATE: begin
          // evaluator latches the path length on this beat
          busy_nxt      = 1'b1;
          allow_cap_nxt = rule_allows_r;
          ovf_cap_nxt   = pat_ovf_r | path_ovf_r;
          path_len_nxt  = '0;
          path_ovf_nxt  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_allows_r <= 1'b0;
      pat_len_r     <= '0;
      path_len_r    <= '0;
      pat_ovf_r     <= 1'b0;
      path_ovf_r    <= 1'b0;
      busy_r        <= 1'b0;
    end else begin
      rule_allows_r <= rule_allows_nxt;
      pat_len_r     <= pat_len_nxt;
      path_len_r    <= path_len_nxt;
      pat_ovf_r     <= pat_ovf_nxt;
      path_ovf_r    <= path_ovf_nxt;
      busy_r        <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    allow_cap_r <= allow_cap_nxt;
    ovf_cap_r   <= ovf_cap_nxt;
  end

  rrpm_ram #(
    .WIDTH (8),
    .DEPTH (rrpm_pkg::PATTERN_MAX)
  ) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_len_r[rrpm_pkg::PAT_AW-1:0]),
    .wdata (in_data_byte),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  rrpm_ram #(
    .WIDTH (8),
    .DEPTH (rrpm_pkg::PATH_MAX)
  ) u_path_ram (
    .clk   (clk),
    .we    (path_we),
    .waddr (path_len_r[rrpm_pkg::PATH_AW-1:0]),
    .wdata (in_data_byte),
    .raddr (path_raddr),
    .rdata (path_rdata)
  );

  rrpm_eval u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (ev_req),
    .pat_raddr  (pat_raddr),
    .pat_rdata  (pat_rdata),
    .path_raddr (path_raddr),
    .path_rdata (path_rdata),
    .sts        (ev_sts)
  );

  assign busy           = busy_r;
  assign out_valid      = ev_sts.done;
  assign out_matched    = ev_sts.matched;
  assign out_allow_rule = allow_cap_r;
  assign out_overflowed = ovf_cap_r;

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy_r)
    else $error("result strobe outside an evaluation");

  a_strobe_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_busy_until_result: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !out_valid) |=> busy_r)
    else $error("busy dropped without a result");

  a_no_store_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (!pat_we && !path_we))
    else $error("store written during evaluation");

endmodule

@@ src/rrpm_ram.sv @@
module rrpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/rrpm_eval.sv @@
module rrpm_eval (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rrpm_pkg::eval_req_t           req,
  output logic [rrpm_pkg::PAT_AW-1:0]   pat_raddr,
  input  logic [7:0]                    pat_rdata,
  output logic [rrpm_pkg::PATH_AW-1:0]  path_raddr,
  input  logic [7:0]                    path_rdata,
  output rrpm_pkg::eval_sts_t           sts
);

  localparam int PAT_LW  = rrpm_pkg::PAT_LW;
  localparam int PATH_LW = rrpm_pkg::PATH_LW;
  localparam int CMP_W   = rrpm_pkg::CMP_W;

  rrpm_pkg::ev_state_t state_r, state_nxt;

  logic [PAT_LW-1:0]  k_r, k_nxt;
  logic [PAT_LW-1:0]  eff_r, eff_nxt;
  logic [PAT_LW-1:0]  np_r, np_nxt;
  logic [PAT_LW-1:0]  snp_r, snp_nxt;
  logic [PATH_LW-1:0] hlen_r, hlen_nxt;
  logic [PATH_LW-1:0] hp_r, hp_nxt;
  logic [PATH_LW-1:0] shp_r, shp_nxt;
  logic               anch_r, anch_nxt;
  logic               trim_r, trim_nxt;
  logic               first_r, first_nxt;
  logic               star_r, star_nxt;
  logic               wild_r, wild_nxt;
  logic               res_r, res_nxt;
  logic [7:0]         nb_r, nb_nxt;

  logic [PATH_LW-1:0] hp_inc;
  logic [PAT_LW-1:0]  eff_dec;
  logic               pat_is_star;
  logic               byte_eq;
  logic               skip_eq;
  logic               at_end;
  logic               walk_more;
  logic               anch_end;
  logic               len_ok;
  logic               can_back;

  assign hp_inc      = PATH_LW'(hp_r + 1'b1);
  assign eff_dec     = PAT_LW'(eff_r - 1'b1);
  assign pat_is_star = (pat_rdata == rrpm_pkg::STAR);
  assign byte_eq     = (pat_rdata == path_rdata);
  assign skip_eq     = (nb_r == path_rdata);
  assign at_end      = (hp_inc == hlen_r);
  assign walk_more   = (hp_r < hlen_r) && (np_r < eff_r);
  assign anch_end    = (np_r == eff_dec);
  assign can_back    = (shp_r != '0) || (snp_r != '0);
  assign len_ok      = anch_r ? (CMP_W'(hlen_r) == CMP_W'(eff_dec))
                              : (CMP_W'(hlen_r) >= CMP_W'(eff_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rrpm_pkg::EV_IDLE: begin
        if (req.start) begin
          state_nxt = (req.pat_len == '0) ? rrpm_pkg::EV_DONE : rrpm_pkg::EV_SCAN_RD;
        end
      end
      rrpm_pkg::EV_SCAN_RD:  state_nxt = rrpm_pkg::EV_SCAN_DAT;
      rrpm_pkg::EV_SCAN_DAT: begin
        state_nxt = (k_r == '0) ? rrpm_pkg::EV_DECIDE : rrpm_pkg::EV_SCAN_RD;
      end
      rrpm_pkg::EV_DECIDE: begin
        if (star_r) begin
          state_nxt = rrpm_pkg::EV_WALK_TOP;
        end else if (len_ok) begin
          state_nxt = rrpm_pkg::EV_CMP_RD;
        end else begin
          state_nxt = rrpm_pkg::EV_DONE;
        end
      end
      rrpm_pkg::EV_CMP_RD: begin
        state_nxt = (k_r == eff_r) ? rrpm_pkg::EV_DONE : rrpm_pkg::EV_CMP_DAT;
      end
      rrpm_pkg::EV_CMP_DAT: begin
        state_nxt = byte_eq ? rrpm_pkg::EV_CMP_RD : rrpm_pkg::EV_DONE;
      end
      rrpm_pkg::EV_WALK_TOP: begin
        state_nxt = walk_more ? rrpm_pkg::EV_WALK_DAT : rrpm_pkg::EV_DONE;
      end
      rrpm_pkg::EV_WALK_DAT: begin
        if (pat_is_star) begin
          state_nxt = rrpm_pkg::EV_STAR_RD;
        end else if (wild_r) begin
          if (byte_eq) begin
            state_nxt = rrpm_pkg::EV_WALK_TOP;
          end else begin
            state_nxt = at_end ? rrpm_pkg::EV_DONE : rrpm_pkg::EV_SKIP_DAT;
          end
        end else if (byte_eq || can_back) begin
          state_nxt = rrpm_pkg::EV_WALK_TOP;
        end else begin
          state_nxt = rrpm_pkg::EV_DONE;
        end
      end
      rrpm_pkg::EV_SKIP_DAT: begin
        if (skip_eq) begin
          state_nxt = rrpm_pkg::EV_WALK_TOP;
        end else if (at_end) begin
          state_nxt = rrpm_pkg::EV_DONE;
        end
      end
      rrpm_pkg::EV_STAR_RD: begin
        state_nxt = (np_r < eff_r) ? rrpm_pkg::EV_STAR_DAT : rrpm_pkg::EV_WALK_TOP;
      end
      rrpm_pkg::EV_STAR_DAT: begin
        state_nxt = pat_is_star ? rrpm_pkg::EV_STAR_RD : rrpm_pkg::EV_WALK_TOP;
      end
      rrpm_pkg::EV_DONE: state_nxt = rrpm_pkg::EV_IDLE;
      default:           state_nxt = rrpm_pkg::EV_IDLE;
    endcase
  end

  // outputs: memory read addresses and status
  always_comb begin
    pat_raddr   = '0;
    path_raddr  = '0;
    sts.done    = 1'b0;
    sts.matched = res_r;
    case (state_r)
      rrpm_pkg::EV_SCAN_RD: pat_raddr = k_r[rrpm_pkg::PAT_AW-1:0];
      rrpm_pkg::EV_CMP_RD: begin
        pat_raddr  = k_r[rrpm_pkg::PAT_AW-1:0];
        path_raddr = rrpm_pkg::PATH_AW'(k_r);
      end
      rrpm_pkg::EV_WALK_TOP: begin
        pat_raddr  = np_r[rrpm_pkg::PAT_AW-1:0];
        path_raddr = hp_r[rrpm_pkg::PATH_AW-1:0];
      end
      // skipping ahead in the path: fetch the byte after hp
      rrpm_pkg::EV_WALK_DAT: path_raddr = hp_inc[rrpm_pkg::PATH_AW-1:0];
      rrpm_pkg::EV_SKIP_DAT: path_raddr = hp_inc[rrpm_pkg::PATH_AW-1:0];
      rrpm_pkg::EV_STAR_RD:  pat_raddr  = np_r[rrpm_pkg::PAT_AW-1:0];
      rrpm_pkg::EV_DONE:     sts.done   = 1'b1;
      default: begin
      end
    endcase
  end

  // datapath
  always_comb begin
    k_nxt     = k_r;
    eff_nxt   = eff_r;
    np_nxt    = np_r;
    snp_nxt   = snp_r;
    hlen_nxt  = hlen_r;
    hp_nxt    = hp_r;
    shp_nxt   = shp_r;
    anch_nxt  = anch_r;
    trim_nxt  = trim_r;
    first_nxt = first_r;
    star_nxt  = star_r;
    wild_nxt  = wild_r;
    res_nxt   = res_r;
    nb_nxt    = nb_r;
    case (state_r)
      rrpm_pkg::EV_IDLE: begin
        k_nxt     = PAT_LW'(req.pat_len - 1'b1);
        eff_nxt   = req.pat_len;
        hlen_nxt  = req.path_len;
        first_nxt = 1'b1;
        trim_nxt  = 1'b1;
        star_nxt  = 1'b0;
        anch_nxt  = 1'b0;
        res_nxt   = 1'b1;
      end
      rrpm_pkg::EV_SCAN_DAT: begin
        // walking down from the last byte: trailing stars trim, others flag
        first_nxt = 1'b0;
        if (first_r) begin
          anch_nxt = (pat_rdata == rrpm_pkg::DOLLAR);
        end
        if (trim_r && pat_is_star) begin
          eff_nxt = k_r;
        end else begin
          trim_nxt = 1'b0;
          if (pat_is_star) begin
            star_nxt = 1'b1;
          end
        end
        k_nxt = PAT_LW'(k_r - 1'b1);
      end
      rrpm_pkg::EV_DECIDE: begin
        np_nxt   = '0;
        snp_nxt  = '0;
        hp_nxt   = '0;
        shp_nxt  = '0;
        wild_nxt = 1'b0;
        k_nxt    = '0;
        if (!star_r) begin
          res_nxt = len_ok;
          if (anch_r) begin
            eff_nxt = eff_dec;
          end
        end
      end
      rrpm_pkg::EV_CMP_RD: res_nxt = 1'b1;
      rrpm_pkg::EV_CMP_DAT: begin
        k_nxt   = PAT_LW'(k_r + 1'b1);
        res_nxt = byte_eq;
      end
      rrpm_pkg::EV_WALK_TOP: begin
        res_nxt = anch_r ? ((hp_r == hlen_r) && anch_end) : (np_r == eff_r);
      end
      rrpm_pkg::EV_WALK_DAT: begin
        if (pat_is_star) begin
          wild_nxt = 1'b1;
          np_nxt   = PAT_LW'(np_r + 1'b1);
        end else if (wild_r) begin
          if (byte_eq) begin
            wild_nxt = 1'b0;
          end else begin
            hp_nxt  = hp_inc;
            nb_nxt  = pat_rdata;
            res_nxt = anch_r && anch_end;
          end
        end else if (byte_eq) begin
          np_nxt = PAT_LW'(np_r + 1'b1);
          hp_nxt = hp_inc;
        end else if (can_back) begin
          // restart one byte later from the last star
          wild_nxt = 1'b1;
          shp_nxt  = PATH_LW'(shp_r + 1'b1);
          hp_nxt   = PATH_LW'(shp_r + 1'b1);
          np_nxt   = snp_r;
        end else begin
          res_nxt = 1'b0;
        end
      end
      rrpm_pkg::EV_SKIP_DAT: begin
        if (skip_eq) begin
          wild_nxt = 1'b0;
        end else begin
          hp_nxt  = hp_inc;
          res_nxt = anch_r && anch_end;
        end
      end
      rrpm_pkg::EV_STAR_RD: begin
        if (np_r >= eff_r) begin
          shp_nxt = hp_r;
          snp_nxt = np_r;
        end
      end
      rrpm_pkg::EV_STAR_DAT: begin
        if (pat_is_star) begin
          np_nxt = PAT_LW'(np_r + 1'b1);
        end else begin
          shp_nxt = hp_r;
          snp_nxt = np_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrpm_pkg::EV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    eff_r   <= eff_nxt;
    np_r    <= np_nxt;
    snp_r   <= snp_nxt;
    hlen_r  <= hlen_nxt;
    hp_r    <= hp_nxt;
    shp_r   <= shp_nxt;
    anch_r  <= anch_nxt;
    trim_r  <= trim_nxt;
    first_r <= first_nxt;
    star_r  <= star_nxt;
    wild_r  <= wild_nxt;
    res_r   <= res_nxt;
    nb_r    <= nb_nxt;
  end

endmodule

@@ tb/sv/robots_rule_path_matcher_top_test.sv @@
module robots_rule_path_matcher_top_test;

  localparam int LIMIT_CYCLES     = 2_000_000;
  localparam int RULE_ALLOWS_ADDR = 4 * rrpm_pkg::REG_RULE_ALLOWS;
  localparam int SPARE_ADDR       = RULE_ALLOWS_ADDR + 4;
  localparam int PHASE_BEATS      = 575;

  localparam logic [7:0] CH_A     = "a";
  localparam logic [7:0] CH_B     = "b";
  localparam logic [7:0] CH_SLASH = "/";

  typedef struct {
    bit         pause;
    logic [1:0] op;
    logic [7:0] data;
  } beat_t;

  typedef struct packed {
    logic matched;
    logic allow;
    logic ovf;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_op = rrpm_pkg::OP_CLEAR_PAT;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_matched;
  logic        out_allow_rule;
  logic        out_overflowed;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [rrpm_pkg::CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  robots_rule_path_matcher_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_data_byte  (in_data_byte),
    .out_valid     (out_valid),
    .out_matched   (out_matched),
    .out_allow_rule(out_allow_rule),
    .out_overflowed(out_overflowed),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // matcher state as the testbench sees it
  logic [7:0] rule_bytes [rrpm_pkg::PATTERN_MAX];
  logic [7:0] url_bytes  [rrpm_pkg::PATH_MAX];
  int         rule_len = 0;
  int         url_len = 0;
  logic       rule_ovf = 1'b0;
  logic       url_ovf = 1'b0;
  logic       allow_reg = 1'b0;

  beat_t      cmd_q [$];
  verdict_t   verdict_q [$];
  verdict_t   want;
  beat_t      cur_beat;
  bit         sending = 1'b0;
  int         beats_in = 0;
  int         beats_sent = 0;
  int         queued_beats = 0;
  int         send_idle_pct = 9;
  int         errors = 0;
  int         results_seen = 0;
  int         cycle_cnt = 0;
  logic [7:0] gen_rule [$];

  task automatic flag_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endtask

  function automatic bit wildcard_walk(int nlen, bit full);
    int         hp = 0;
    int         shp = 0;
    int         np = 0;
    int         snp = 0;
    bit         in_wild = 1'b0;
    logic [7:0] nb;
    logic [7:0] hb;
    while (hp < url_len && np < nlen) begin
      nb = rule_bytes[np];
      if (nb != rrpm_pkg::STAR) begin
        if (in_wild) begin
          while (hp < url_len && nb != url_bytes[hp]) hp++;
          if (hp == url_len) return full && (np + 1) == nlen;
          in_wild = 1'b0;
          continue;
        end
        hb = url_bytes[hp];
        np++;
        hp++;
        if (nb == hb) continue;
        // only a mismatch after some star may retry, one path byte further on
        if (shp != 0 || snp != 0) begin
          in_wild = 1'b1;
          shp++;
          hp = shp;
          np = snp;
          continue;
        end
        return 1'b0;
      end
      in_wild = 1'b1;
      while (np < nlen && rule_bytes[np] == rrpm_pkg::STAR) np++;
      shp = hp;
      snp = np;
    end
    if (full) return hp == url_len && (np + 1) == nlen;
    return np == nlen;
  endfunction

  function automatic bit path_matches();
    int plen;
    bit anchored;
    bit has_star = 1'b0;
    plen = rule_len;
    if (plen == 0) return 1'b1;
    anchored = rule_bytes[plen-1] == rrpm_pkg::DOLLAR;
    if (!anchored) begin
      while (plen > 0 && rule_bytes[plen-1] == rrpm_pkg::STAR) plen--;
    end
    for (int i = 0; i < plen; i++) begin
      if (rule_bytes[i] == rrpm_pkg::STAR) has_star = 1'b1;
    end
    if (has_star) return wildcard_walk(plen, anchored);
    if (anchored) plen--;
    if (anchored ? (url_len != plen) : (url_len < plen)) return 1'b0;
    for (int i = 0; i < plen; i++) begin
      if (url_bytes[i] != rule_bytes[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic apply_beat(logic [1:0] op, logic [7:0] b);
    verdict_t v;
    case (op)
      rrpm_pkg::OP_CLEAR_PAT: begin
        rule_len = 0;
        rule_ovf = 1'b0;
      end
      rrpm_pkg::OP_APPEND_PAT: begin
        if (rule_len < rrpm_pkg::PATTERN_MAX) begin
          rule_bytes[rule_len] = b;
          rule_len++;
        end else begin
          rule_ovf = 1'b1;
        end
      end
      rrpm_pkg::OP_APPEND_PATH: begin
        if (url_len < rrpm_pkg::PATH_MAX) begin
          url_bytes[url_len] = b;
          url_len++;
        end else begin
          url_ovf = 1'b1;
        end
      end
      default: begin
        v.matched = path_matches();
        v.allow   = allow_reg;
        v.ovf     = rule_ovf | url_ovf;
        verdict_q.push_back(v);
        url_len = 0;
        url_ovf = 1'b0;
      end
    endcase
  endtask

  // driver: one beat in flight, held until taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (sending && beats_in != beats_sent) begin
        sending = 1'b0;
        beats_sent = beats_in;
      end
      if (!sending && cmd_q.size() > 0) begin
        if (cmd_q[0].pause) begin
          if (verdict_q.size() == 0) void'(cmd_q.pop_front());
        end else if ($urandom_range(0, 99) >= send_idle_pct) begin
          cur_beat = cmd_q.pop_front();
          sending = 1'b1;
        end
      end
      start        <= sending;
      in_op        <= sending ? cur_beat.op : 2'($urandom);
      in_data_byte <= sending ? cur_beat.data : 8'($urandom);
    end
  end

  // monitor: check the result first, then take the beat of this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (verdict_q.size() == 0) begin
          flag_error($sformatf("unexpected result m/a/o=%0b/%0b/%0b",
                               out_matched, out_allow_rule, out_overflowed));
        end else begin
          want = verdict_q.pop_front();
          if (out_matched !== want.matched || out_allow_rule !== want.allow ||
              out_overflowed !== want.ovf)
            flag_error($sformatf("result %0d: m/a/o expected %0b/%0b/%0b got %0b/%0b/%0b",
                                 results_seen, want.matched, want.allow, want.ovf,
                                 out_matched, out_allow_rule, out_overflowed));
          results_seen++;
        end
      end
      if (start && !busy) begin
        apply_beat(in_op, in_data_byte);
        beats_in++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic apb_xfer(input logic wr, input int addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr[rrpm_pkg::CFG_AW-1:0];
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_rule_allows(logic v);
    logic [31:0] rd;
    // unmapped slot must not disturb the register
    apb_xfer(1'b1, SPARE_ADDR, $urandom, rd);
    apb_xfer(1'b1, RULE_ALLOWS_ADDR, {31'($urandom), v}, rd);
    allow_reg = v;
    apb_xfer(1'b0, RULE_ALLOWS_ADDR, 32'h0, rd);
    if (rd[0] !== allow_reg)
      flag_error($sformatf("rule_allows readback %0b, expected %0b", rd[0], allow_reg));
  endtask

  task automatic queue_beat(logic [1:0] op, logic [7:0] b);
    beat_t t;
    t.pause = 1'b0;
    t.op    = op;
    t.data  = b;
    cmd_q.push_back(t);
    queued_beats++;
  endtask

  task automatic queue_pause();
    beat_t t;
    t.pause = 1'b1;
    t.op    = rrpm_pkg::OP_CLEAR_PAT;
    t.data  = 8'h00;
    cmd_q.push_back(t);
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return CH_A;
      3:       return CH_B;
      4:       return CH_SLASH;
      5:       return rrpm_pkg::STAR;
      6:       return rrpm_pkg::DOLLAR;
      7:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // one rule/path pair and its evaluate; paths mostly follow the rule so
  // that both verdicts show up
  task automatic queue_rule_case();
    int         r;
    int         n;
    logic [7:0] c;
    logic [7:0] url [$];
    r = $urandom_range(0, 99);
    if (gen_rule.size() == 0 || r < 60) begin
      queue_beat(rrpm_pkg::OP_CLEAR_PAT, 8'($urandom));
      gen_rule.delete();
      r = $urandom_range(0, 99);
      n = (r < 3) ? $urandom_range(60, 70) : (r < 8) ? 0 : $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        c = pick_char();
        gen_rule.push_back(c);
        queue_beat(rrpm_pkg::OP_APPEND_PAT, c);
      end
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      foreach (gen_rule[i]) begin
        if (gen_rule[i] == rrpm_pkg::STAR) begin
          n = $urandom_range(0, 3);
          repeat (n) url.push_back(pick_char());
        end else if (!(gen_rule[i] == rrpm_pkg::DOLLAR && i == gen_rule.size() - 1)) begin
          url.push_back(gen_rule[i]);
        end
      end
      if (url.size() > 0 && $urandom_range(0, 9) == 0)
        url[$urandom_range(0, url.size() - 1)] = pick_char();
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) url.push_back(pick_char());
      end
    end else begin
      n = (r < 62) ? $urandom_range(250, 262) : $urandom_range(0, 10);
      repeat (n) url.push_back(pick_char());
    end
    foreach (url[i]) queue_beat(rrpm_pkg::OP_APPEND_PATH, url[i]);
    queue_beat(rrpm_pkg::OP_EVALUATE, 8'($urandom));
    if ($urandom_range(0, 29) == 0) queue_pause();
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) queue_beat(2'($urandom), 8'($urandom));
    end
  endtask

  task automatic drain(int settle);
    while (cmd_q.size() != 0 || sending || verdict_q.size() != 0 || busy !== 1'b0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic random_phase(int idle_pct);
    int stop_at;
    send_idle_pct = idle_pct;
    stop_at = queued_beats + PHASE_BEATS;
    queue_rule_case();
    queue_pause();
    while (queued_beats < stop_at) queue_rule_case();
    drain(8);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_rule_allows(1'b1);

    // empty pattern, empty and nonempty path
    queue_beat(rrpm_pkg::OP_EVALUATE, 8'h00);
    queue_beat(rrpm_pkg::OP_APPEND_PATH, 8'hFF);
    queue_beat(rrpm_pkg::OP_EVALUATE, 8'hFF);
    // pattern of stars only
    queue_beat(rrpm_pkg::OP_APPEND_PAT, rrpm_pkg::STAR);
    queue_beat(rrpm_pkg::OP_APPEND_PAT, rrpm_pkg::STAR);
    queue_beat(rrpm_pkg::OP_APPEND_PATH, CH_A);
    queue_beat(rrpm_pkg::OP_EVALUATE, 8'h00);
    // anchored wildcard, hit then miss
    queue_beat(rrpm_pkg::OP_CLEAR_PAT, 8'hFF);
    queue_beat(rrpm_pkg::OP_APPEND_PAT, CH_A);
    queue_beat(rrpm_pkg::OP_APPEND_PAT, rrpm_pkg::STAR);
    queue_beat(rrpm_pkg::OP_APPEND_PAT, CH_B);
    queue_beat(rrpm_pkg::OP_APPEND_PAT, rrpm_pkg::DOLLAR);
    queue_beat(rrpm_pkg::OP_APPEND_PATH, CH_A);
    queue_beat(rrpm_pkg::OP_APPEND_PATH, CH_A);
    queue_beat(rrpm_pkg::OP_APPEND_PATH, CH_B);
    queue_beat(rrpm_pkg::OP_EVALUATE, 8'h00);
    queue_beat(rrpm_pkg::OP_APPEND_PATH, CH_A);
    queue_beat(rrpm_pkg::OP_APPEND_PATH, CH_B);
    queue_beat(rrpm_pkg::OP_APPEND_PATH, CH_A);
    queue_beat(rrpm_pkg::OP_EVALUATE, 8'h00);
    // plain prefix, then exact with anchor
    queue_beat(rrpm_pkg::OP_CLEAR_PAT, 8'h00);
    queue_beat(rrpm_pkg::OP_APPEND_PAT, 8'h00);
    queue_beat(rrpm_pkg::OP_APPEND_PATH, 8'h00);
    queue_beat(rrpm_pkg::OP_APPEND_PATH, CH_A);
    queue_beat(rrpm_pkg::OP_EVALUATE, 8'h00);
    queue_beat(rrpm_pkg::OP_APPEND_PAT, rrpm_pkg::DOLLAR);
    queue_beat(rrpm_pkg::OP_APPEND_PATH, 8'h00);
    queue_beat(rrpm_pkg::OP_EVALUATE, 8'hFF);
    drain(8);

    set_rule_allows(1'b0);
    random_phase(9);
    set_rule_allows(1'b1);
    random_phase(86);
    set_rule_allows(1'b0);
    random_phase(0);

    drain(50);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
